>>> rtl/sud_pkg.sv
// ----------------------------------------------------------------------------
// sud_pkg
// Shared widths and stage types for the pipelined restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sud_pkg;

    // Operand width that the array works on; the port fields stay 64 bits.
    localparam int WIDTH   = 64;
    localparam int FIELD_W = 64;
    localparam int DATA_W  = 2 * FIELD_W;

    localparam logic [WIDTH-1:0] MIN_NEG = {1'b1, {(WIDTH - 1){1'b0}}};
    localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};

    // Per-item facts that ride along the array untouched.
    typedef struct packed {
        logic             err;
        logic             qneg;
        logic             rneg;
        logic [WIDTH-1:0] orig;
    } t_side;

    // What one pipeline stage hands to the next.
    typedef struct packed {
        logic             vld;
        logic [WIDTH-1:0] d;
        logic [WIDTH-1:0] r;
        logic [WIDTH-1:0] nq;
        t_side            side;
    } t_stage;

endpackage

`default_nettype wire

>>> rtl/sud_prep.sv
// ----------------------------------------------------------------------------
// sud_prep
// Input stage: error detection, operand magnitudes and sign bookkeeping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sud_prep (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [sud_pkg::FIELD_W-1:0]   i_dividend,
    input  wire logic [sud_pkg::FIELD_W-1:0]   i_divisor,
    input  wire logic                          i_mode,
    input  wire logic                          i_ready,
    output sud_pkg::t_stage                    o_stage
);

    logic                         r_vld;
    sud_pkg::t_stage              r_data;
    sud_pkg::t_stage              n_data;
    logic [sud_pkg::WIDTH-1:0]    n_val;
    logic [sud_pkg::WIDTH-1:0]    d_val;
    logic                         nneg;
    logic                         dneg;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        n_val = i_dividend[sud_pkg::WIDTH-1:0];
        d_val = i_divisor[sud_pkg::WIDTH-1:0];
        nneg  = i_mode && n_val[sud_pkg::WIDTH-1];
        dneg  = i_mode && d_val[sud_pkg::WIDTH-1];

        n_data           = '0;
        n_data.vld       = 1'b1;
        n_data.side.err  = (d_val == '0) ||
                           (i_mode && n_val == sud_pkg::MIN_NEG &&
                            d_val == sud_pkg::ALL_ONES);
        n_data.side.qneg = nneg ^ dneg;
        n_data.side.rneg = nneg;
        n_data.side.orig = n_val;
        n_data.d         = dneg ? (-d_val) : d_val;
        n_data.nq        = nneg ? (-n_val) : n_val;
        n_data.r         = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_stage     = r_data;
        o_stage.vld = r_vld;
    end

endmodule

`default_nettype wire

>>> rtl/sud_cell.sv
// ----------------------------------------------------------------------------
// sud_cell
// One restoring shift-subtract step of the divider array.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sud_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sud_pkg::t_stage    i_stage,
    output logic                    o_ready,
    input  wire logic               i_ready,
    output sud_pkg::t_stage         o_stage
);

    logic                         r_vld;
    sud_pkg::t_stage              r_data;
    sud_pkg::t_stage              n_data;
    logic [sud_pkg::WIDTH-1:0]    shifted;
    logic [sud_pkg::WIDTH:0]      diff;
    logic                         take;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        // Bring the next dividend bit into the partial remainder. The bit
        // that falls off the top acts as the extra top bit of the compare.
        shifted = {i_stage.r[sud_pkg::WIDTH-2:0], i_stage.nq[sud_pkg::WIDTH-1]};
        diff    = {i_stage.r[sud_pkg::WIDTH-1], shifted} - {1'b0, i_stage.d};
        take    = !diff[sud_pkg::WIDTH];

        n_data    = i_stage;
        n_data.r  = take ? diff[sud_pkg::WIDTH-1:0] : shifted;
        // Quotient bits fill the low end as dividend bits leave the top.
        n_data.nq = {i_stage.nq[sud_pkg::WIDTH-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_stage.vld;
        end
        if (o_ready && i_stage.vld) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_stage     = r_data;
        o_stage.vld = r_vld;
    end

    // For items without an error, the partial remainder stays below the divisor.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !r_data.side.err) |-> (r_data.r < r_data.d))
        else $error("partial remainder not below divisor");

    // An item taken in shows up in this stage on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_stage.vld) |=> r_vld)
        else $error("accepted item lost in cell");

    // A stalled stage keeps its contents.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !i_ready) |=> (r_vld && $stable(r_data)))
        else $error("stalled cell changed");

endmodule

`default_nettype wire

>>> rtl/sud_post.sv
// ----------------------------------------------------------------------------
// sud_post
// Output stage: sign fix-up, error substitution and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sud_post (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sud_pkg::t_stage               i_stage,
    output logic                               o_ready,
    input  wire logic                          i_ready,
    output logic                               o_valid,
    output logic [sud_pkg::FIELD_W-1:0]        o_quotient,
    output logic [sud_pkg::FIELD_W-1:0]        o_remainder,
    output logic                               o_error
);

    logic                         r_vld;
    logic [sud_pkg::WIDTH-1:0]    r_quo;
    logic [sud_pkg::WIDTH-1:0]    r_rem;
    logic                         r_err;
    logic [sud_pkg::WIDTH-1:0]    n_quo;
    logic [sud_pkg::WIDTH-1:0]    n_rem;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        if (i_stage.side.err) begin
            n_quo = sud_pkg::ALL_ONES;
            n_rem = i_stage.side.orig;
        end else begin
            n_quo = i_stage.side.qneg ? (-i_stage.nq) : i_stage.nq;
            n_rem = i_stage.side.rneg ? (-i_stage.r) : i_stage.r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_stage.vld;
        end
        if (o_ready && i_stage.vld) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_err <= i_stage.side.err;
        end
    end

    assign o_valid     = r_vld;
    assign o_quotient  = sud_pkg::FIELD_W'(r_quo);
    assign o_remainder = sud_pkg::FIELD_W'(r_rem);
    assign o_error     = r_err;

endmodule

`default_nettype wire

>>> rtl/signed_unsigned_divider_64_top.sv
// ----------------------------------------------------------------------------
// signed_unsigned_divider_64_top
// Pipelined 64-bit signed/unsigned restoring divider with stream ports.
// ----------------------------------------------------------------------------
// The divider takes one item per clock while the output side keeps up, and
// each item passes one input stage that forms the operand magnitudes, a row
// of 64 cells that each produce one quotient bit with one 65-bit subtract,
// and one output stage that restores the signs. Every stage holds only while
// the stage after it is full and stalled, so bubbles close up and input items
// keep flowing into empty stages while a finished result waits. Division by
// zero, and the most negative value divided by minus one in signed mode, set
// divide_error with an all-ones quotient and the dividend as the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_unsigned_divider_64_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [63:0] dividend, [127:64] divisor
    input  wire logic [sud_pkg::DATA_W-1:0]    s_axis_tdata,
    // [0] mode
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [63:0] quotient, [127:64] remainder
    output logic [sud_pkg::DATA_W-1:0]         m_axis_tdata,
    // [0] divide_error
    output logic                               m_axis_tuser
);

    sud_pkg::t_stage                     stage [0:sud_pkg::WIDTH];
    logic [sud_pkg::WIDTH:0]             rdy;
    logic [sud_pkg::FIELD_W-1:0]         quo;
    logic [sud_pkg::FIELD_W-1:0]         rem;

    sud_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_dividend (s_axis_tdata[sud_pkg::FIELD_W-1:0]),
        .i_divisor  (s_axis_tdata[sud_pkg::DATA_W-1:sud_pkg::FIELD_W]),
        .i_mode     (s_axis_tuser),
        .i_ready    (rdy[0]),
        .o_stage    (stage[0])
    );

    for (genvar k = 0; k < sud_pkg::WIDTH; k++) begin : g_cell
        sud_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (stage[k]),
            .o_ready (rdy[k]),
            .i_ready (rdy[k+1]),
            .o_stage (stage[k+1])
        );
    end

    sud_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (stage[sud_pkg::WIDTH]),
        .o_ready     (rdy[sud_pkg::WIDTH]),
        .i_ready     (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_quotient  (quo),
        .o_remainder (rem),
        .o_error     (m_axis_tuser)
    );

    assign m_axis_tdata = {rem, quo};

endmodule

`default_nettype wire
